@@ src/tbp_pkg.sv @@
// Shared constants and types for the token bucket policer.
// No dependencies; every other file refers to this package by scoped name.
`default_nettype none
package tbp_pkg;

  localparam int NUM_USERS = 256;
  localparam int FRAC_BITS = 16;

  localparam int USER_IN_W = 8;
  localparam int USER_W    = $clog2(NUM_USERS);
  localparam int TIME_W    = 48;
  localparam int CAP_W     = 16;
  localparam int RATE_W    = 32;
  localparam int LVL_W     = CAP_W + FRAC_BITS;
  localparam int PROD_W    = LVL_W + RATE_W;
  localparam int ENTRY_W   = TIME_W + LVL_W;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_BUCKET_CAPACITY = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_REFILL_RATE     = CFG_ADDR_W'(1);

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(5);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(33);

  localparam logic [LVL_W-1:0] ONE_TOKEN = LVL_W'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ELAP = 4'b0010,
    S_MUL  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  typedef struct packed {
    logic elap_en;
    logic mul_en;
  } dp_ctrl_t;

endpackage
`default_nettype wire

@@ src/tbp_ifs.sv @@
// Valid/ready channel interfaces for the token bucket policer:
// request, result and configuration write. Depends on tbp_pkg.
`default_nettype none
interface tbp_in_if;
  logic                         valid;
  logic                         ready;
  logic [tbp_pkg::USER_IN_W-1:0] user_index;
  logic [tbp_pkg::TIME_W-1:0]    time_ms;
  modport source (output valid, user_index, time_ms, input ready);
  modport sink   (input valid, user_index, time_ms, output ready);
endinterface

interface tbp_out_if;
  logic                      valid;
  logic                      ready;
  logic                      allowed;
  logic [tbp_pkg::CAP_W-1:0] tokens_left;
  modport source (output valid, allowed, tokens_left, input ready);
  modport sink   (input valid, allowed, tokens_left, output ready);
endinterface

interface tbp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tbp_pkg::CFG_ADDR_W-1:0] addr;
  logic [tbp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

@@ src/tbp_refill.sv @@
// Refill datapath: elapsed time, refill product, saturation and token take.
// Two registered stages plus the final update logic. Depends on tbp_pkg.
`default_nettype none
module tbp_refill (
  input  wire                          clk,
  input  wire  tbp_pkg::dp_ctrl_t      ctrl,
  input  wire                          first_seen,
  input  wire  [tbp_pkg::LVL_W-1:0]    level_rd,
  input  wire  [tbp_pkg::TIME_W-1:0]   time_rd,
  input  wire  [tbp_pkg::TIME_W-1:0]   now,
  input  wire  [tbp_pkg::CAP_W-1:0]    capacity,
  input  wire  [tbp_pkg::RATE_W-1:0]   rate,
  output logic [tbp_pkg::LVL_W-1:0]    level_new,
  output logic                         allowed
);

  logic [tbp_pkg::LVL_W-1:0]  cap_q;
  logic [tbp_pkg::TIME_W-1:0] elapsed;
  logic [tbp_pkg::LVL_W-1:0]  base_nxt;
  logic                       big_nxt;

  logic [tbp_pkg::LVL_W-1:0]  elap_r;
  logic                       big_r;
  logic [tbp_pkg::LVL_W-1:0]  base_r;
  logic [tbp_pkg::PROD_W-1:0] prod_r;
  logic                       sat_r;

  logic [tbp_pkg::PROD_W-1:0] sum;
  logic [tbp_pkg::LVL_W-1:0]  capped;

  assign cap_q = {capacity, {tbp_pkg::FRAC_BITS{1'b0}}};

  always_comb begin
    if (first_seen || (now < time_rd)) begin
      elapsed = '0;
    end else begin
      elapsed = now - time_rd;
    end
    big_nxt = (|elapsed[tbp_pkg::TIME_W-1:tbp_pkg::LVL_W]) && (|rate);
    if (first_seen || (level_rd > cap_q)) begin
      base_nxt = cap_q;
    end else begin
      base_nxt = level_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.elap_en) begin
      elap_r <= elapsed[tbp_pkg::LVL_W-1:0];
      big_r  <= big_nxt;
      base_r <= base_nxt;
    end
    if (ctrl.mul_en) begin
      prod_r <= tbp_pkg::PROD_W'(elap_r) * tbp_pkg::PROD_W'(rate);
      sat_r  <= big_r;
    end
  end

  always_comb begin
    sum = prod_r + tbp_pkg::PROD_W'(base_r);
    if (sat_r || (sum > tbp_pkg::PROD_W'(cap_q))) begin
      capped = cap_q;
    end else begin
      capped = sum[tbp_pkg::LVL_W-1:0];
    end
    allowed = (capped >= tbp_pkg::ONE_TOKEN);
    if (allowed) begin
      level_new = capped - tbp_pkg::ONE_TOKEN;
    end else begin
      level_new = capped;
    end
  end

endmodule
`default_nettype wire

@@ src/token_bucket_policer.sv @@
// Top level of the per-user token bucket policer: bucket memory, seen bits,
// sequencer, configuration registers and result register.
// Depends on tbp_pkg, tbp_ifs and tbp_refill.
//
// Usage:
//   in_chan carries one request (user_index, time_ms) per transfer. out_chan
//   returns one result (allowed, tokens_left) per request, in order. cfg_chan
//   writes bucket_capacity (index 0) and refill_rate_q16 (index 1); other
//   indexes are ignored. Write configuration only while no request is open.
//   Each request goes through these steps in order: accept and memory read,
//   elapsed time, refill multiply, then update and write-back of the user's
//   entry. The result is registered in the update step and shows on out_chan.
//   A new request is accepted only once the previous one has written back, so
//   requests never overlap; this is set by the read-modify-write of the single
//   bucket memory.
//   Reset clears the seen bit of every user and restores capacity 5 and rate
//   33; bucket contents need no clearing since a user's first request sets
//   them. When out_chan stalls, the finished result waits in its register
//   and the next request holds in the update step until the result is taken.
`default_nettype none
module token_bucket_policer (
  input  wire               clk,
  input  wire               rst_n,
  tbp_in_if.sink            in_chan,
  tbp_out_if.source         out_chan,
  tbp_cfg_if.sink           cfg_chan
);

  tbp_pkg::state_t state_r, state_nxt;

  logic [tbp_pkg::ENTRY_W-1:0]   bucket_mem [tbp_pkg::NUM_USERS];
  logic [tbp_pkg::ENTRY_W-1:0]   entry_rd_r;
  logic [tbp_pkg::NUM_USERS-1:0] seen_r;

  logic [tbp_pkg::USER_W-1:0] user_r;
  logic [tbp_pkg::TIME_W-1:0] now_r;
  logic [tbp_pkg::CAP_W-1:0]  cap_r;
  logic [tbp_pkg::RATE_W-1:0] rate_r;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_allowed_r;
  logic [tbp_pkg::CAP_W-1:0] out_tokens_r;

  logic                       in_fire;
  logic                       upd_go;
  logic [tbp_pkg::USER_W-1:0] in_idx;
  tbp_pkg::dp_ctrl_t          dp_ctrl;
  logic [tbp_pkg::LVL_W-1:0]  level_new;
  logic                       allowed;

  assign in_chan.ready  = (state_r == tbp_pkg::S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign in_idx         = in_chan.user_index[tbp_pkg::USER_W-1:0];
  assign upd_go         = (state_r == tbp_pkg::S_UPD) && (!out_valid_r || out_chan.ready);
  assign cfg_chan.ready = 1'b1;

  assign dp_ctrl.elap_en = (state_r == tbp_pkg::S_ELAP);
  assign dp_ctrl.mul_en  = (state_r == tbp_pkg::S_MUL);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbp_pkg::S_IDLE: if (in_fire) state_nxt = tbp_pkg::S_ELAP;
      tbp_pkg::S_ELAP: state_nxt = tbp_pkg::S_MUL;
      tbp_pkg::S_MUL:  state_nxt = tbp_pkg::S_UPD;
      tbp_pkg::S_UPD:  if (upd_go) state_nxt = tbp_pkg::S_IDLE;
      default:         state_nxt = tbp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (upd_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      cap_r       <= tbp_pkg::CAP_RESET;
      rate_r      <= tbp_pkg::RATE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd_go) begin
        seen_r[user_r] <= 1'b1;
      end
      if (cfg_chan.valid) begin
        case (cfg_chan.addr)
          tbp_pkg::REG_BUCKET_CAPACITY: cap_r  <= cfg_chan.data[tbp_pkg::CAP_W-1:0];
          tbp_pkg::REG_REFILL_RATE:     rate_r <= cfg_chan.data[tbp_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      user_r     <= in_idx;
      now_r      <= in_chan.time_ms;
      entry_rd_r <= bucket_mem[in_idx];
    end
    if (upd_go) begin
      bucket_mem[user_r] <= {now_r, level_new};
      out_allowed_r      <= allowed;
      out_tokens_r       <= level_new[tbp_pkg::LVL_W-1:tbp_pkg::FRAC_BITS];
    end
  end

  tbp_refill u_refill (
    .clk        (clk),
    .ctrl       (dp_ctrl),
    .first_seen (!seen_r[user_r]),
    .level_rd   (entry_rd_r[tbp_pkg::LVL_W-1:0]),
    .time_rd    (entry_rd_r[tbp_pkg::ENTRY_W-1:tbp_pkg::LVL_W]),
    .now        (now_r),
    .capacity   (cap_r),
    .rate       (rate_r),
    .level_new  (level_new),
    .allowed    (allowed)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.allowed     = out_allowed_r;
  assign out_chan.tokens_left = out_tokens_r;

endmodule
`default_nettype wire

@@ src/tbp_checker.sv @@
// Port-level checks for token_bucket_policer, attached with bind.
// Depends on tbp_pkg and the top level's channel interfaces.
`default_nettype none
module tbp_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire                      out_allowed,
  input wire [tbp_pkg::CAP_W-1:0] out_tokens_left
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_allowed) && $stable(out_tokens_left))
    else $error("result changed while stalled");

  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_allowed |-> out_tokens_left == '0)
    else $error("rejected request reports tokens left");

  a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is open");

endmodule

bind token_bucket_policer tbp_checker u_tbp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_allowed     (out_chan.allowed),
  .out_tokens_left (out_chan.tokens_left)
);
`default_nettype wire
